@@ hw/rtl/agre_pkg.sv @@
// agre_pkg: shared types and constants for the annular gap radius enforcer.
// Used by every RTL file of the block; depends on nothing.
package agre_pkg;

  localparam int COORD_W  = 32;  // signed Q16.16 centre coordinate
  localparam int RADIUS_W = 31;  // unsigned Q15.16 radius
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SUM_W    = SQ_W + 2;       // three squares
  localparam int ROOT_W   = SUM_W / 2;      // truncated root of the sum
  localparam int NEED_W   = RADIUS_W + 4;   // distance + inner + gap
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 4;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INNER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd1;

  // per-point data riding alongside the root computation
  typedef struct packed {
    logic [RADIUS_W-1:0] r_out;
    logic [RADIUS_W-1:0] r_in;      // already raised to the minimum
    logic                raised;
    logic                viol;
    logic                last;
  } side_t;

  // token handed from cell to cell
  typedef struct packed {
    logic [SUM_W-1:0]  rem;   // sum of squares minus root squared
    logic [ROOT_W-1:0] root;
    side_t             side;
  } tok_t;

endpackage

@@ hw/rtl/annular_gap_radius_enforcer_core.sv @@
// annular_gap_radius_enforcer_core: top level, config registers and the cell chain.
// Depends on agre_pkg, agre_front, agre_sqrt_cell, agre_back.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: 6 coords, 2 radii; tlast: last_point
//   out_    | out | out_tvalid/tready  | tdata: 2 radii; tuser: 4 flags; tlast: last_out
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One point per cycle sustained while out_tready stays high; a result passes through
// 37 registers: 3 front stages, 33 root cells, one per root bit, 1 output stage.
// Each stage holds one transaction and moves on when the next stage is empty or moving.
// Synchronous active-low reset clears valids and config; cfg_ready is always high.
// A stalled output fills the chain stage by stage before in_tready drops.
module annular_gap_radius_enforcer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] outer_x, [63:32] outer_y, [95:64] outer_z, [127:96] inner_x,
  // [159:128] inner_y, [191:160] inner_z, [222:192] outer_radius,
  // [253:223] inner_radius, [255:254] zero
  input  logic [agre_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [30:0] new_outer_radius, [61:31] new_inner_radius, [63:62] zero
  output logic [agre_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] inner_raised, [1] gap_widened, [2] outer_saturated, [3] order_violation
  output logic [agre_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [agre_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [agre_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NCELL = agre_pkg::ROOT_W;

  logic [agre_pkg::RADIUS_W-1:0] min_inner_r, min_gap_r;
  logic                          v   [NCELL+1];
  logic                          rdy [NCELL+1];
  agre_pkg::tok_t                tok [NCELL+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_inner_r <= '0;
      min_gap_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        agre_pkg::CFG_MIN_INNER: min_inner_r <= cfg_data[agre_pkg::RADIUS_W-1:0];
        agre_pkg::CFG_MIN_GAP:   min_gap_r   <= cfg_data[agre_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  agre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .ox        (in_tdata[31:0]),
    .oy        (in_tdata[63:32]),
    .oz        (in_tdata[95:64]),
    .ix        (in_tdata[127:96]),
    .iy        (in_tdata[159:128]),
    .iz        (in_tdata[191:160]),
    .r_out     (in_tdata[222:192]),
    .r_in      (in_tdata[253:223]),
    .last      (in_tlast),
    .min_inner (min_inner_r),
    .dn_valid  (v[0]),
    .dn_ready  (rdy[0]),
    .dn_tok    (tok[0])
  );

  // cell i settles root bit NCELL-1-i, most significant first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    agre_sqrt_cell #(
      .BIT (NCELL - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_tok   (tok[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_tok   (tok[i+1])
    );
  end

  agre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (v[NCELL]),
    .up_ready   (rdy[NCELL]),
    .up_tok     (tok[NCELL]),
    .min_gap    (min_gap_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/agre_front.sv @@
// agre_front: input stages (absolute deltas, squares, sum of squares), inner raise and order check.
// Depends on agre_pkg.
module agre_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [agre_pkg::COORD_W-1:0]    ox,
  input  logic [agre_pkg::COORD_W-1:0]    oy,
  input  logic [agre_pkg::COORD_W-1:0]    oz,
  input  logic [agre_pkg::COORD_W-1:0]    ix,
  input  logic [agre_pkg::COORD_W-1:0]    iy,
  input  logic [agre_pkg::COORD_W-1:0]    iz,
  input  logic [agre_pkg::RADIUS_W-1:0]   r_out,
  input  logic [agre_pkg::RADIUS_W-1:0]   r_in,
  input  logic                            last,
  input  logic [agre_pkg::RADIUS_W-1:0]   min_inner,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output agre_pkg::tok_t                  dn_tok
);

  logic                          va_r, vb_r, vc_r;
  logic                          rdy_a, rdy_b, rdy_c;
  logic [agre_pkg::COORD_W-1:0]  dx_r, dy_r, dz_r;
  logic [agre_pkg::SQ_W-1:0]     sx_r, sy_r, sz_r;
  logic [agre_pkg::SUM_W-1:0]    sum_r;
  agre_pkg::side_t               side_a_r, side_b_r, side_c_r;
  agre_pkg::side_t               side_nxt;
  logic [agre_pkg::COORD_W-1:0]  dx_nxt, dy_nxt, dz_nxt;

  function automatic logic [agre_pkg::COORD_W-1:0] abs_diff(
    input logic [agre_pkg::COORD_W-1:0] a,
    input logic [agre_pkg::COORD_W-1:0] b
  );
    logic [agre_pkg::COORD_W:0] d;
    d = {a[agre_pkg::COORD_W-1], a} - {b[agre_pkg::COORD_W-1], b};
    if (d[agre_pkg::COORD_W]) begin
      d = -d;
    end
    return d[agre_pkg::COORD_W-1:0];
  endfunction

  assign rdy_c    = !vc_r || dn_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    dx_nxt          = abs_diff(ox, ix);
    dy_nxt          = abs_diff(oy, iy);
    dz_nxt          = abs_diff(oz, iz);
    side_nxt.r_out  = r_out;
    side_nxt.raised = r_in < min_inner;
    side_nxt.r_in   = side_nxt.raised ? min_inner : r_in;
    side_nxt.viol   = (r_in == '0) || (r_out <= r_in);
    side_nxt.last   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      dz_r     <= dz_nxt;
      side_a_r <= side_nxt;
    end
    if (rdy_b && va_r) begin
      sx_r     <= dx_r * dx_r;
      sy_r     <= dy_r * dy_r;
      sz_r     <= dz_r * dz_r;
      side_b_r <= side_a_r;
    end
    if (rdy_c && vb_r) begin
      sum_r    <= {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};
      side_c_r <= side_b_r;
    end
  end

  assign dn_valid    = vc_r;
  assign dn_tok.rem  = sum_r;
  assign dn_tok.root = '0;
  assign dn_tok.side = side_c_r;

endmodule

@@ hw/rtl/agre_sqrt_cell.sv @@
// agre_sqrt_cell: one cell of the square root chain, settles root bit BIT.
// Depends on agre_pkg.
module agre_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  agre_pkg::tok_t  up_tok,
  output logic            dn_valid,
  input  logic            dn_ready,
  output agre_pkg::tok_t  dn_tok
);

  localparam int TW = agre_pkg::SUM_W + 2;

  logic            v_r;
  agre_pkg::tok_t  tok_r, tok_nxt;
  logic [TW-1:0]   trial;
  logic [TW-1:0]   rem_ext;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    trial   = ({{(TW-agre_pkg::ROOT_W){1'b0}}, up_tok.root} << (BIT + 1))
            + ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
    rem_ext = {2'b00, up_tok.rem};
    tok_nxt = up_tok;
    if (rem_ext >= trial) begin
      tok_nxt.rem       = up_tok.rem - trial[agre_pkg::SUM_W-1:0];
      tok_nxt.root[BIT] = 1'b1;
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

endmodule

@@ hw/rtl/agre_back.sv @@
// agre_back: gap check, outer radius bump with saturation, output register.
// Depends on agre_pkg.
module agre_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  agre_pkg::tok_t                      up_tok,
  input  logic [agre_pkg::RADIUS_W-1:0]       min_gap,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [agre_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [agre_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  logic                              v_r;
  logic [agre_pkg::RADIUS_W-1:0]     new_out_r, new_in_r;
  logic                              raised_r, widened_r, sat_r, viol_r, last_r;
  logic [agre_pkg::NEED_W-1:0]       need;
  logic                              widened_nxt, sat_nxt;
  logic [agre_pkg::RADIUS_W-1:0]     new_out_nxt;

  always_comb begin
    need = {{(agre_pkg::NEED_W-agre_pkg::ROOT_W){1'b0}}, up_tok.root}
         + {{(agre_pkg::NEED_W-agre_pkg::RADIUS_W){1'b0}}, up_tok.side.r_in}
         + {{(agre_pkg::NEED_W-agre_pkg::RADIUS_W){1'b0}}, min_gap};
    widened_nxt = {{(agre_pkg::NEED_W-agre_pkg::RADIUS_W){1'b0}}, up_tok.side.r_out} < need;
    sat_nxt     = widened_nxt && (need[agre_pkg::NEED_W-1:agre_pkg::RADIUS_W] != '0);
    if (!widened_nxt) begin
      new_out_nxt = up_tok.side.r_out;
    end else if (sat_nxt) begin
      new_out_nxt = agre_pkg::RADIUS_MAX;
    end else begin
      new_out_nxt = need[agre_pkg::RADIUS_W-1:0];
    end
  end

  assign up_ready = !v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      new_out_r <= new_out_nxt;
      new_in_r  <= up_tok.side.r_in;
      raised_r  <= up_tok.side.raised;
      widened_r <= widened_nxt;
      sat_r     <= sat_nxt;
      viol_r    <= up_tok.side.viol;
      last_r    <= up_tok.side.last;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = {{(agre_pkg::OUT_DATA_W-2*agre_pkg::RADIUS_W){1'b0}}, new_in_r, new_out_r};
  assign out_tuser  = {viol_r, sat_r, widened_r, raised_r};
  assign out_tlast  = last_r;

endmodule

@@ hw/rtl/agre_checker.sv @@
// agre_checker: port-level assertions for annular_gap_radius_enforcer_core.
// Depends on agre_pkg; bound to the top level at the end of this file.
module agre_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [agre_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [agre_pkg::OUT_USER_W-1:0]   out_tuser,
  input logic                              out_tlast
);

  // saturation only happens on a widened outer radius
  a_sat_needs_widen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("outer_saturated without gap_widened");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[30:0] == agre_pkg::RADIUS_MAX)
    else $error("saturated outer radius not at maximum");

  // a widened outer radius always leaves room above the inner one
  a_widen_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] && !out_tuser[2] |-> out_tdata[30:0] >= out_tdata[61:31])
    else $error("widened outer radius below inner radius");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind annular_gap_radius_enforcer_core agre_checker u_agre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ test/annular_gap_radius_enforcer_core_tb.sv @@
// Self-checking bench for annular_gap_radius_enforcer_core: random and corner grid points
// go in, and each result is checked against an in-bench model of the gap rule.
// Depends on agre_pkg and the core RTL only.
module annular_gap_radius_enforcer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [30:0] RAD_TOP = 31'h7FFF_FFFF;

  typedef struct {
    logic [31:0] ox, oy, oz;
    logic [31:0] ix, iy, iz;
    logic [30:0] r_out;
    logic [30:0] r_in;
    logic        last;
  } wall_point_t;

  typedef struct {
    logic [30:0] new_out;
    logic [30:0] new_in;
    logic        raised;
    logic        widened;
    logic        sat;
    logic        viol;
    logic        last;
  } radii_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [agre_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                              in_tlast = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [agre_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [agre_pkg::OUT_USER_W-1:0]   out_tuser;
  logic                              out_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [agre_pkg::CFG_IDX_W-1:0]    cfg_index = agre_pkg::CFG_MIN_INNER;
  logic [agre_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  annular_gap_radius_enforcer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // bench copy of the two limit registers
  logic [30:0] min_inner_q = '0;
  logic [30:0] min_gap_q   = '0;

  wall_point_t points_todo[$];
  radii_t      radii_due[$];
  wall_point_t on_bus;
  logic        in_took  = 1'b0;
  logic        cfg_took = 1'b0;

  int errors = 0;
  int n_points = 0, n_raised = 0, n_widened = 0, n_sat = 0, n_viol = 0, n_last = 0;
  int hold_asks = 0;

  function automatic logic [32:0] abs_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d < 0 ? 33'(-d) : 33'(d);
  endfunction

  // truncated centre distance, then raise inner and widen outer as needed
  function automatic radii_t enforce_gap(wall_point_t p);
    logic [32:0] dx, dy, dz;
    logic [65:0] dsq;
    logic [34:0] dist_q, trial;
    logic [69:0] trial_sq;
    logic [36:0] need;
    radii_t      r;
    dx = abs_diff(p.ox, p.ix);
    dy = abs_diff(p.oy, p.iy);
    dz = abs_diff(p.oz, p.iz);
    dsq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
    dist_q = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = dist_q | (35'd1 << b);
      trial_sq = 70'(trial) * 70'(trial);
      if (trial_sq <= 70'(dsq)) dist_q = trial;
    end
    r.viol   = (p.r_in == '0) || (p.r_out <= p.r_in);
    r.raised = p.r_in < min_inner_q;
    r.new_in = r.raised ? min_inner_q : p.r_in;
    need = 37'(dist_q) + 37'(r.new_in) + 37'(min_gap_q);
    r.widened = 37'(p.r_out) < need;
    r.sat     = r.widened && (need > 37'(RAD_TOP));
    r.new_out = r.sat ? RAD_TOP : (r.widened ? 31'(need) : p.r_out);
    r.last    = p.last;
    return r;
  endfunction

  function automatic wall_point_t mk_point(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                           logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                                           logic [30:0] r_out, logic [30:0] r_in, logic last);
    wall_point_t p;
    p.ox = ox; p.oy = oy; p.oz = oz;
    p.ix = ix; p.iy = iy; p.iz = iz;
    p.r_out = r_out; p.r_in = r_in; p.last = last;
    return p;
  endfunction

  function automatic logic [31:0] nearby_coord(logic [31:0] c);
    logic [31:0] step;
    step = $urandom() >> $urandom_range(2, 31);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 1) ? c + step : c - step;
  endfunction

  // mostly well-formed points with the outer radius near the gap boundary
  function automatic wall_point_t random_point();
    wall_point_t p, probe;
    radii_t      g;
    longint      span;
    int          kind;
    p.ox = $urandom(); p.oy = $urandom(); p.oz = $urandom();
    p.ix = nearby_coord(p.ox);
    p.iy = nearby_coord(p.oy);
    p.iz = nearby_coord(p.oz);
    p.r_in = 31'($urandom() >> $urandom_range(1, 31));
    p.last = ($urandom_range(0, 7) == 0);
    probe = p;
    probe.r_out = '0;
    g = enforce_gap(probe);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: span = longint'(g.new_out) + int'($urandom_range(0, 6)) - 3;
      4, 5:       span = longint'(g.new_out) + longint'($urandom() >> $urandom_range(1, 31));
      6:          span = longint'(p.r_in) - longint'($urandom() >> $urandom_range(1, 31));
      7: begin
        if ($urandom_range(0, 1) == 1) p.r_in = '0;
        span = longint'($urandom() >> $urandom_range(1, 31));
      end
      default:    span = longint'($urandom() >> 1);
    endcase
    if (span < 0) span = 0;
    if (span > longint'(RAD_TOP)) span = longint'(RAD_TOP);
    p.r_out = 31'(span);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [30:0] got, logic [30:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // sampling edge: output check first, then capture of the accepted input
  always @(posedge clk) begin
    radii_t want;
    in_took  <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (radii_due.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata, 0);
        end else begin
          want = radii_due.pop_front();
          check_field("new_outer_radius", out_tdata[30:0], want.new_out);
          check_field("new_inner_radius", out_tdata[61:31], want.new_in);
          check_field("inner_raised", out_tuser[0], want.raised);
          check_field("gap_widened", out_tuser[1], want.widened);
          check_field("outer_saturated", out_tuser[2], want.sat);
          check_field("order_violation", out_tuser[3], want.viol);
          check_field("last_out", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        want = enforce_gap(on_bus);
        radii_due.push_back(want);
        n_points++;
        n_raised  += want.raised;
        n_widened += want.widened;
        n_sat     += want.sat;
        n_viol    += want.viol;
        n_last    += want.last;
      end
    end
  end

  // sender: bursts of random length, random gaps in between
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    wall_point_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (points_todo.size() > 0) begin
        p = points_todo.pop_front();
        on_bus = p;
        burst_left--;
        in_tdata  <= {2'b00, p.r_in, p.r_out, p.iz, p.iy, p.ix, p.oz, p.oy, p.ox};
        in_tlast  <= p.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: switches among stall modes; a long hold-off on request
  int          hold_seen = 0, hold_left = 0, mode = 0, mode_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  always @(negedge clk) begin
    logic rdy;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 120);
        stall_pat = $urandom();
      end else begin
        mode_left--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = stall_pat[0];
      endcase
    end
    out_tready <= rdy;
  end

  task automatic write_reg(logic [agre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_took);
    if (idx == agre_pkg::CFG_MIN_INNER) min_inner_q = value[30:0];
    else min_gap_q = value[30:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [31:0] min_inner, logic [31:0] gap);
    write_reg(agre_pkg::CFG_MIN_INNER, min_inner);
    write_reg(agre_pkg::CFG_MIN_GAP, gap);
  endtask

  task automatic add_random(int count);
    repeat (count) points_todo.push_back(random_point());
  endtask

  task automatic wait_drained();
    while (points_todo.size() != 0 || in_tvalid || radii_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_limit();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // limits at zero: corner geometry and radii
    set_limits(32'h0, 32'h0);
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    points_todo.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   RAD_TOP, 31'd1, 1'b0));
    points_todo.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   '0, RAD_TOP, 1'b1));
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, RAD_TOP, RAD_TOP, 1'b0));
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, 31'd1, 31'd0, 1'b0));
    // 3-4-12 gives an exact root of 13: on the boundary, then one below it
    points_todo.push_back(mk_point(32'd3, 32'd4, 32'd12, '0, '0, '0, 31'd23, 31'd10, 1'b0));
    points_todo.push_back(mk_point(32'd3, -32'sd4, 32'd12, '0, '0, '0, 31'd22, 31'd10, 1'b0));
    // root of 3 truncates to 1
    points_todo.push_back(mk_point(32'd1, 32'd1, 32'd1, '0, '0, '0, 31'd2, 31'd1, 1'b0));
    points_todo.push_back(mk_point(32'd1, 32'd1, 32'd1, '0, '0, '0, 31'd1, 31'd1, 1'b1));
    // bumped outer lands exactly on the maximum, then one past it
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, RAD_TOP - 31'd1, RAD_TOP, 1'b0));
    points_todo.push_back(mk_point(32'd1, '0, '0, '0, '0, '0, '0, RAD_TOP, 1'b0));
    points_todo.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                   32'h0001_8000, 32'h0002_0000, 32'h0003_0000,
                                   31'h0002_0000, 31'h0001_0000, 1'b0));
    points_todo.push_back(mk_point(-32'sh0005_0000, 32'h0000_4000, -32'sh0000_0001,
                                   32'h0005_0000, -32'sh0000_4000, 32'h7FFF_FFFF,
                                   31'h5555_5555, 31'h2AAA_AAAA, 1'b1));
    add_random(100);
    wait_drained();

    // nonzero limits: raising and the gap boundary
    set_limits(32'h0001_0000, 32'h0000_8000);
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, 31'h0001_8000, 31'h0000_FFFF, 1'b0));
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, 31'h0001_8000, 31'h0001_0000, 1'b0));
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, 31'h0001_7FFF, 31'h0001_0000, 1'b1));
    points_todo.push_back(mk_point(32'd3, 32'd4, 32'd12, '0, '0, '0,
                                   31'h0001_800D, 31'h0000_0005, 1'b0));
    points_todo.push_back(mk_point(32'd3, 32'd4, 32'd12, '0, '0, '0,
                                   31'h0001_800C, 31'h0000_0005, 1'b0));
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, 31'd0, 31'd0, 1'b1));
    add_random(240);
    wait_drained();

    // every limit at full scale; bit 31 of the write data must be dropped
    set_limits(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    points_todo.push_back(mk_point('0, '0, '0, '0, '0, '0, RAD_TOP, RAD_TOP, 1'b0));
    add_random(60);
    wait_drained();

    set_limits(32'h0, 32'hFFFF_FFFF);
    add_random(200);
    wait_drained();

    // receiver holds off for a long stretch while the sender keeps going
    set_limits(random_limit(), random_limit());
    add_random(250);
    @(posedge clk);
    hold_asks++;
    wait_drained();

    set_limits(32'h7FFF_FFFF, 32'h0);
    add_random(60);
    wait_drained();

    repeat (5) begin
      set_limits(random_limit(), random_limit());
      add_random(200);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("%0d points checked: %0d inner raised, %0d gap widened, %0d outer saturated,",
             n_points, n_raised, n_widened, n_sat);
    $display("%0d order violations, %0d wall ends, 11 limit settings", n_viol, n_last);
    if (errors == 0) begin
      $display("annular_gap_radius_enforcer_core_tb: clean");
    end else begin
      $display("annular_gap_radius_enforcer_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", radii_due.size());
    $display("annular_gap_radius_enforcer_core_tb: errors");
    $finish;
  end

endmodule
